// ===== design/calclk_pkg.sv =====
// Shared types, constants and calendar helper functions for the calendar clock counter.
// Depends on nothing; imported by every other design file.
`default_nettype none

package calclk_pkg;

    // millisecond ticks per second
    localparam int unsigned TICKS_PER_SECOND = 1000;
    localparam int unsigned TICK_W = $clog2(TICKS_PER_SECOND + 1);

    // field widths
    localparam int unsigned OP_W     = 2;
    localparam int unsigned SEC_W    = 6;
    localparam int unsigned MIN_W    = 6;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned DAYIN_W  = 6;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned YEAR_W   = 12;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ADDR_W   = 3;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_DATE = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_TIME = 2'd2;
    localparam logic [OP_W-1:0] OP_SET_ALL  = 2'd3;

    // register indexes (paddr bit 2 selects)
    localparam logic REG_MIN_YEAR = 1'b0;
    localparam logic REG_MAX_YEAR = 1'b1;

    // reset values
    localparam logic [YEAR_W-1:0] MIN_YEAR_RESET = 12'd2024;
    localparam logic [YEAR_W-1:0] MAX_YEAR_RESET = 12'd2035;
    localparam logic [YEAR_W-1:0] YEAR_RESET     = 12'd2024;

    // calendar limits
    localparam logic [SEC_W-1:0]   SEC_LAST   = 6'd59;
    localparam logic [MIN_W-1:0]   MIN_LAST   = 6'd59;
    localparam logic [HOUR_W-1:0]  HOUR_LAST  = 5'd23;
    localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR  = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN  = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP  = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV  = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [YEAR_W-1:0]  YEAR_LAST  = 12'd4095;

    // year limits from the configuration registers
    typedef struct packed {
        logic [YEAR_W-1:0] min_year;
        logic [YEAR_W-1:0] max_year;
    } cfg_t;

    // gregorian leap year: divisible by 4, and not by 100 unless by 400
    // divisibility by 25 through a reciprocal multiply, exact for 12-bit years
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [24:0] prod;
        logic [7:0]  q;
        logic [12:0] back;
        logic        div4;
        logic        div16;
        logic        div25;
        prod  = 25'(y) * 25'd5243;
        q     = prod[24:17];
        back  = 13'(q) * 13'd25;
        div25 = (back == {1'b0, y});
        div4  = (y[1:0] == 2'd0);
        div16 = (y[3:0] == 4'd0);
        return div4 && (!div25 || div16);
    endfunction

    // days in month m
    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== design/calclk_regs.sv =====
// APB-style configuration registers: year limits for date loads.
// Depends on calclk_pkg.
`default_nettype none

module calclk_regs (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [calclk_pkg::ADDR_W-1:0] paddr,
    input  wire logic [calclk_pkg::DATA_W-1:0] pwdata,
    output logic      [calclk_pkg::DATA_W-1:0] prdata,
    output logic                           pready,
    output calclk_pkg::cfg_t               cfg
);
    import calclk_pkg::*;

    logic [YEAR_W-1:0] min_year_reg;
    logic [YEAR_W-1:0] max_year_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_year_reg <= MIN_YEAR_RESET;
            max_year_reg <= MAX_YEAR_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_MIN_YEAR)
            begin
                min_year_reg <= pwdata[YEAR_W-1:0];
            end
            else
            begin
                max_year_reg <= pwdata[YEAR_W-1:0];
            end
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        case (paddr[2])
            REG_MIN_YEAR: prdata = DATA_W'(min_year_reg);
            REG_MAX_YEAR: prdata = DATA_W'(max_year_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.min_year = min_year_reg;
    assign cfg.max_year = max_year_reg;

endmodule

`default_nettype wire

// ===== design/calclk_core.sv =====
// Clock and calendar state, updated once per accepted word.
// The state registers double as the result register. Depends on calclk_pkg.
`default_nettype none

module calclk_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire calclk_pkg::cfg_t              cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [calclk_pkg::OP_W-1:0]    operation,
    input  wire logic [calclk_pkg::DAYIN_W-1:0] day_in,
    input  wire logic [calclk_pkg::MONTH_W-1:0] month_in,
    input  wire logic [calclk_pkg::YEAR_W-1:0]  year_in,
    input  wire logic [calclk_pkg::HOUR_W-1:0]  hour_in,
    input  wire logic [calclk_pkg::MIN_W-1:0]   minute_in,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [calclk_pkg::SEC_W-1:0]   second_now,
    output logic      [calclk_pkg::MIN_W-1:0]   minute_now,
    output logic      [calclk_pkg::HOUR_W-1:0]  hour_now,
    output logic      [calclk_pkg::DAY_W-1:0]   day_now,
    output logic      [calclk_pkg::MONTH_W-1:0] month_now,
    output logic      [calclk_pkg::YEAR_W-1:0]  year_now
);
    import calclk_pkg::*;

    logic [TICK_W-1:0]  phase_reg,  phase_next;
    logic [SEC_W-1:0]   sec_reg,    sec_next;
    logic [MIN_W-1:0]   min_reg,    min_next;
    logic [HOUR_W-1:0]  hour_reg,   hour_next;
    logic [DAY_W-1:0]   day_reg,    day_next;
    logic [MONTH_W-1:0] month_reg,  month_next;
    logic [YEAR_W-1:0]  year_reg,   year_next;
    logic               valid_reg,  valid_next;

    logic               accept;
    logic [TICK_W:0]    phase_sum;
    logic [DAY_W-1:0]   cur_len;
    logic [YEAR_W-1:0]  year_lo;
    logic [YEAR_W-1:0]  year_ld;
    logic [MONTH_W-1:0] month_ld;
    logic [DAY_W-1:0]   len_ld;
    logic [DAYIN_W-1:0] day_ld;
    logic               do_date;
    logic               do_time;

    // a new word enters whenever the result slot is free or being drained
    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign do_date  = (operation == OP_SET_DATE) || (operation == OP_SET_ALL);
    assign do_time  = (operation == OP_SET_TIME) || (operation == OP_SET_ALL);

    // length of the current month for the day rollover
    assign cur_len   = month_length(month_reg, is_leap(year_reg));
    assign phase_sum = {1'b0, phase_reg} + (TICK_W+1)'(1);

    // clamped date load values; max_year wins when limits cross
    always_comb
    begin
        year_lo  = (year_in < cfg.min_year) ? cfg.min_year : year_in;
        year_ld  = (year_lo > cfg.max_year) ? cfg.max_year : year_lo;
        if (month_in == 4'd0)
        begin
            month_ld = MONTH_JAN;
        end
        else if (month_in > MONTH_DEC)
        begin
            month_ld = MONTH_DEC;
        end
        else
        begin
            month_ld = month_in;
        end
        len_ld = month_length(month_ld, is_leap(year_ld));
        if (day_in == 6'd0)
        begin
            day_ld = DAYIN_W'(DAY_FIRST);
        end
        else if (day_in > DAYIN_W'(len_ld))
        begin
            day_ld = DAYIN_W'(len_ld);
        end
        else
        begin
            day_ld = day_in;
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        valid_next = valid_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next = 1'b1;
            if (operation == OP_TICK)
            begin
                if (phase_sum >= (TICK_W+1)'(TICKS_PER_SECOND))
                begin
                    phase_next = '0;
                    // cascade seconds into minutes, hours, days, months, years
                    if (sec_reg != SEC_LAST)
                    begin
                        sec_next = sec_reg + 6'd1;
                    end
                    else
                    begin
                        sec_next = '0;
                        if (min_reg != MIN_LAST)
                        begin
                            min_next = min_reg + 6'd1;
                        end
                        else
                        begin
                            min_next = '0;
                            if (hour_reg != HOUR_LAST)
                            begin
                                hour_next = hour_reg + 5'd1;
                            end
                            else
                            begin
                                hour_next = '0;
                                if (day_reg < cur_len)
                                begin
                                    day_next = day_reg + 5'd1;
                                end
                                else
                                begin
                                    day_next = DAY_FIRST;
                                    if (month_reg < MONTH_DEC)
                                    begin
                                        month_next = month_reg + 4'd1;
                                    end
                                    else
                                    begin
                                        month_next = MONTH_JAN;
                                        if (year_reg != YEAR_LAST)
                                        begin
                                            year_next = year_reg + 12'd1;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                else
                begin
                    phase_next = phase_sum[TICK_W-1:0];
                end
            end
            else
            begin
                if (do_date)
                begin
                    day_next   = day_ld[DAY_W-1:0];
                    month_next = month_ld;
                    year_next  = year_ld;
                end
                if (do_time)
                begin
                    hour_next  = (hour_in > HOUR_LAST) ? HOUR_LAST : hour_in;
                    min_next   = (minute_in > MIN_LAST) ? MIN_LAST : minute_in;
                    sec_next   = '0;
                    phase_next = '0;
                end
            end
        end
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            sec_reg   <= '0;
            min_reg   <= '0;
            hour_reg  <= '0;
            day_reg   <= DAY_FIRST;
            month_reg <= MONTH_JAN;
            year_reg  <= YEAR_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            sec_reg   <= sec_next;
            min_reg   <= min_next;
            hour_reg  <= hour_next;
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid  = valid_reg;
    assign second_now = sec_reg;
    assign minute_now = min_reg;
    assign hour_now   = hour_reg;
    assign day_now    = day_reg;
    assign month_now  = month_reg;
    assign year_now   = year_reg;

endmodule

`default_nettype wire

// ===== design/calendar_clock_counter.sv =====
// Calendar clock counter: one word per cycle while results are taken, one result word per
// input word, each result showing the clock just after that word. A word is a millisecond
// tick, a date load, a time load or both; loads are clamped to legal values, the year to
// the min_year/max_year registers at APB byte addresses 0 and 4. Results show in the
// cycle after acceptance: the whole update (tick cascade or clamped load) settles between
// the state registers, which also hold the result, so in_ready stays high while the
// result is taken in the same cycle. Depends on calclk_pkg, calclk_regs and calclk_core.
`default_nettype none

module calendar_clock_counter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [calclk_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [calclk_pkg::DATA_W-1:0]  pwdata,
    output logic      [calclk_pkg::DATA_W-1:0]  prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [calclk_pkg::OP_W-1:0]    operation,
    input  wire logic [calclk_pkg::DAYIN_W-1:0] day_in,
    input  wire logic [calclk_pkg::MONTH_W-1:0] month_in,
    input  wire logic [calclk_pkg::YEAR_W-1:0]  year_in,
    input  wire logic [calclk_pkg::HOUR_W-1:0]  hour_in,
    input  wire logic [calclk_pkg::MIN_W-1:0]   minute_in,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [calclk_pkg::SEC_W-1:0]   second_now,
    output logic      [calclk_pkg::MIN_W-1:0]   minute_now,
    output logic      [calclk_pkg::HOUR_W-1:0]  hour_now,
    output logic      [calclk_pkg::DAY_W-1:0]   day_now,
    output logic      [calclk_pkg::MONTH_W-1:0] month_now,
    output logic      [calclk_pkg::YEAR_W-1:0]  year_now
);
    import calclk_pkg::*;

    cfg_t cfg;

    // configuration registers
    calclk_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // clock and calendar datapath
    calclk_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .day_in     (day_in),
        .month_in   (month_in),
        .year_in    (year_in),
        .hour_in    (hour_in),
        .minute_in  (minute_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .second_now (second_now),
        .minute_now (minute_now),
        .hour_now   (hour_now),
        .day_now    (day_now),
        .month_now  (month_now),
        .year_now   (year_now)
    );

    // while a result is valid, seconds, minutes, hours and months are in range and day is at least 1
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (second_now <= SEC_LAST && minute_now <= MIN_LAST &&
                       hour_now <= HOUR_LAST && day_now >= DAY_FIRST &&
                       month_now >= MONTH_JAN && month_now <= MONTH_DEC))
        else $error("clock field out of range");

    // a time load restarts the second
    a_set_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && operation[1]) |=> (out_valid && second_now == '0))
        else $error("time load did not clear seconds");

    // a date load never exceeds the configured maximum year
    a_set_year: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && operation[0]) |=> (year_now <= cfg.max_year))
        else $error("date load above max_year");

    // a waiting result blocks new words
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("word accepted over a pending result");

endmodule

`default_nettype wire
